// File: design/mtg_pkg.sv
// Shared types, constants and the tempering function of the MT19937 generator.
// Used by mtg_front, mtg_back and the top level; depends on nothing else.
package mtg_pkg;

  // Default sizes of the state store and the twist tap
  localparam int STATE_WORDS_DEF = 624;
  localparam int TAP_OFFSET_DEF  = 397;

  // Depth of the command queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // Algorithm constants
  localparam logic [31:0] TWIST_XOR = 32'h9908_b0df;
  localparam logic [31:0] LOW_MASK  = 32'h7fff_ffff;
  localparam logic [31:0] SEED_MUL  = 32'd1812433253;
  localparam logic [31:0] TEMPER_B  = 32'h9d2c_5680;
  localparam logic [31:0] TEMPER_C  = 32'hefc6_0000;

  // Command codes
  typedef enum logic {
    OP_SEED = 1'b0,
    OP_DRAW = 1'b1
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [31:0] seed;
  } cmd_t;

  // Head of the command queue as seen by the back part
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_head_t;

  // Output tempering
  function automatic logic [31:0] temper(input logic [31:0] w);
    logic [31:0] y;
    y = w;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage

// File: design/mersenne_twister_generator.sv
// Top level of the MT19937 generator: front queue plus back sequencer.
// Depends on mtg_pkg, mtg_front and mtg_back.

// A beat is taken when start is high and busy is low; up to two commands wait
// in the queue, and busy is high while it is full. A seed beat writes word 0
// directly, then runs one multiply and one add state per further store word,
// and gives no result. A draw gives one word on out_random_word, read from the
// store through its read register and the output register, with out_strobe
// high for exactly one cycle; the receiver cannot stall and must take it then.
// The first draw after a seed, and every 624th draw after that, first runs the
// twist over the 624-word store at one word per cycle (two read ports, one
// write port). A draw before any seed returns zero the cycle after it is popped.
module mersenne_twister_generator #(
  parameter int STATE_WORDS = mtg_pkg::STATE_WORDS_DEF,
  parameter int TAP_OFFSET  = mtg_pkg::TAP_OFFSET_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_action,
  input  logic [31:0] in_seed,
  output logic        out_strobe,
  output logic [31:0] out_random_word
);
  import mtg_pkg::*;

  q_head_t head;
  logic    pop;

  mtg_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_action (in_action),
    .in_seed   (in_seed),
    .busy      (busy),
    .head      (head),
    .pop       (pop)
  );

  mtg_back #(
    .STATE_WORDS (STATE_WORDS),
    .TAP_OFFSET  (TAP_OFFSET)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head            (head),
    .pop             (pop),
    .out_strobe      (out_strobe),
    .out_random_word (out_random_word)
  );

endmodule

// File: design/mtg_front.sv
// Front part of the MT19937 generator: accepts command beats, classifies them
// and holds them in a short queue for the back part. Depends on mtg_pkg.
module mtg_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic             in_action,
  input  logic [31:0]      in_seed,
  output logic             busy,
  output mtg_pkg::q_head_t head,
  input  logic             pop
);
  import mtg_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             entry_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             push;
  logic             do_pop;
  cmd_t             cmd_in;

  // classify the incoming beat
  always_comb begin
    cmd_in.op   = in_action ? OP_DRAW : OP_SEED;
    cmd_in.seed = in_seed;
  end

  assign busy   = (cnt_r == CNT_W'(QUEUE_DEPTH));
  assign push   = start && !busy;
  assign do_pop = pop && (cnt_r != '0);

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !do_pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_pop && !push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // queue storage, payload only
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= cmd_in;
    end
  end

  always_comb begin
    head.valid = (cnt_r != '0);
    head.cmd   = entry_r[rd_ptr_r];
  end

endmodule

// File: design/mtg_back.sv
// Back part of the MT19937 generator: state store, seeding sequencer,
// in-place twist, readout and tempering. Depends on mtg_pkg.
module mtg_back #(
  parameter int STATE_WORDS = mtg_pkg::STATE_WORDS_DEF,
  parameter int TAP_OFFSET  = mtg_pkg::TAP_OFFSET_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  mtg_pkg::q_head_t head,
  output logic             pop,
  output logic             out_strobe,
  output logic [31:0]      out_random_word
);
  import mtg_pkg::*;

  localparam int AW    = $clog2(STATE_WORDS);
  localparam int IDX_W = $clog2(STATE_WORDS + 1);

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_SEED_MUL = 3'd1;
  localparam logic [2:0] ST_SEED_ADD = 3'd2;
  localparam logic [2:0] ST_TW_PRE   = 3'd3;
  localparam logic [2:0] ST_TW_RUN   = 3'd4;
  localparam logic [2:0] ST_RD_WAIT  = 3'd5;

  logic [2:0]       state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             seeded_r, seeded_nxt;
  logic [AW-1:0]    k_r, k_nxt;
  logic [31:0]      prev_r, prev_nxt;
  logic [31:0]      prod_r, prod_nxt;
  logic             hi_r, hi_nxt;
  logic             out_strobe_r, out_strobe_nxt;
  logic [31:0]      out_word_r, out_word_nxt;

  // state store
  logic [31:0]      mem [STATE_WORDS];
  logic             we;
  logic [AW-1:0]    wa;
  logic [31:0]      wd;
  logic [AW-1:0]    ra_a, ra_b;
  logic [31:0]      rd_a_r, rd_b_r;

  // twist datapath
  logic [31:0]      y;
  logic [31:0]      tw_word;
  logic [AW:0]      nx_sum, tap_sum;
  logic [AW-1:0]    nx_addr, tap_addr;
  logic [31:0]      seed_mix;
  logic [31:0]      seed_word;
  logic             last_k;

  assign y       = {hi_r, 31'b0} | (rd_a_r & LOW_MASK);
  assign tw_word = rd_b_r ^ {1'b0, y[31:1]} ^ (y[0] ? TWIST_XOR : 32'h0);

  // read addresses for word k+1 of the twist: its neighbor and its tap
  assign nx_sum   = {1'b0, k_r} + (AW+1)'(2);
  assign tap_sum  = {1'b0, k_r} + (AW+1)'(TAP_OFFSET + 1);
  assign nx_addr  = (nx_sum >= (AW+1)'(STATE_WORDS)) ?
                    AW'(nx_sum - (AW+1)'(STATE_WORDS)) : AW'(nx_sum);
  assign tap_addr = (tap_sum >= (AW+1)'(STATE_WORDS)) ?
                    AW'(tap_sum - (AW+1)'(STATE_WORDS)) : AW'(tap_sum);

  assign seed_mix  = prev_r ^ (prev_r >> 30);
  assign seed_word = prod_r + 32'(k_r);
  assign last_k    = (k_r == AW'(STATE_WORDS - 1));

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    seeded_nxt     = seeded_r;
    k_nxt          = k_r;
    prev_nxt       = prev_r;
    prod_nxt       = prod_r;
    hi_nxt         = hi_r;
    out_strobe_nxt = 1'b0;
    out_word_nxt   = out_word_r;
    pop            = 1'b0;
    we             = 1'b0;
    wa             = k_r;
    wd             = tw_word;
    ra_a           = '0;
    ra_b           = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (head.valid) begin
          pop = 1'b1;
          if (head.cmd.op == OP_SEED) begin
            we        = 1'b1;
            wa        = '0;
            wd        = head.cmd.seed;
            prev_nxt  = head.cmd.seed;
            k_nxt     = AW'(1);
            state_nxt = ST_SEED_MUL;
          end else if (!seeded_r) begin
            // never seeded: the store holds no seeded state, so the draw returns zero
            out_strobe_nxt = 1'b1;
            out_word_nxt   = '0;
          end else if (idx_r >= IDX_W'(STATE_WORDS)) begin
            ra_a      = '0;
            k_nxt     = '0;
            state_nxt = ST_TW_PRE;
          end else begin
            ra_a      = AW'(idx_r);
            idx_nxt   = idx_r + IDX_W'(1);
            state_nxt = ST_RD_WAIT;
          end
        end
      end
      ST_SEED_MUL: begin
        prod_nxt  = SEED_MUL * seed_mix;
        state_nxt = ST_SEED_ADD;
      end
      ST_SEED_ADD: begin
        we       = 1'b1;
        wa       = k_r;
        wd       = seed_word;
        prev_nxt = seed_word;
        if (last_k) begin
          idx_nxt    = IDX_W'(STATE_WORDS);
          seeded_nxt = 1'b1;
          state_nxt  = ST_IDLE;
        end else begin
          k_nxt     = k_r + AW'(1);
          state_nxt = ST_SEED_MUL;
        end
      end
      ST_TW_PRE: begin
        // word 0 is back: keep its top bit, fetch operands of word 0
        hi_nxt    = rd_a_r[31];
        ra_a      = AW'(1);
        ra_b      = AW'(TAP_OFFSET);
        state_nxt = ST_TW_RUN;
      end
      ST_TW_RUN: begin
        we     = 1'b1;
        wa     = k_r;
        wd     = tw_word;
        hi_nxt = rd_a_r[31];
        if (last_k) begin
          ra_a      = '0;
          idx_nxt   = IDX_W'(1);
          state_nxt = ST_RD_WAIT;
        end else begin
          ra_a  = nx_addr;
          ra_b  = tap_addr;
          k_nxt = k_r + AW'(1);
        end
      end
      ST_RD_WAIT: begin
        out_strobe_nxt = 1'b1;
        out_word_nxt   = temper(rd_a_r);
        state_nxt      = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      idx_r        <= IDX_W'(STATE_WORDS);
      seeded_r     <= 1'b0;
      k_r          <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      idx_r        <= idx_nxt;
      seeded_r     <= seeded_nxt;
      k_r          <= k_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    prev_r     <= prev_nxt;
    prod_r     <= prod_nxt;
    hi_r       <= hi_nxt;
    out_word_r <= out_word_nxt;
  end

  // store: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_a_r <= mem[ra_a];
    rd_b_r <= mem[ra_b];
  end

  assign out_strobe      = out_strobe_r;
  assign out_random_word = out_word_r;

endmodule

// File: design/mtg_checker.sv
// Port-level assertions for the MT19937 generator and the bind that attaches
// them to mersenne_twister_generator. Depends on the top level's ports only.
module mtg_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        in_action,
  input logic [31:0] in_seed,
  input logic        out_strobe,
  input logic [31:0] out_random_word
);

  // the queue can only fill up right after a beat was taken
  a_busy_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start && !busy))
    else $error("busy rose without an accepted beat");

  // reset leaves an empty queue and no pending result
  a_reset_idle: assert property (@(posedge clk)
    $rose(rst_n) |-> (!busy && !out_strobe))
    else $error("busy or strobe after reset");

  // no result can appear without a beat taken after reset
  a_no_spurious: assert property (@(posedge clk)
    (!rst_n ##1 (rst_n && !start)) |=> !out_strobe)
    else $error("result strobe without any accepted beat");

  // a seed beat into an empty, idle block yields no result next cycle
  a_seed_quiet: assert property (@(posedge clk)
    (!rst_n ##1 (rst_n && start && !in_action)) |=> !out_strobe)
    else $error("seed beat produced a result");

  // command fields are known while offered, the word is known while strobed
  a_known: assert property (@(posedge clk) disable iff (!rst_n)
    (start |-> !$isunknown({in_action, in_seed})) and
    (out_strobe |-> !$isunknown(out_random_word)))
    else $error("unknown value on a command or result beat");

endmodule

bind mersenne_twister_generator mtg_checker u_mtg_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .in_action       (in_action),
  .in_seed         (in_seed),
  .out_strobe      (out_strobe),
  .out_random_word (out_random_word)
);
